// ----- hdl/bpf_pkg.sv -----
// bpf_pkg: shared types, codes and default sizes of the bucketed priority frontier.
// Used by bpf_ctrl, bpf_dp and bucketed_priority_frontier.
`default_nettype none
package bpf_pkg;
	localparam int DEF_NUM_BUCKETS = 64;
	localparam int DEF_SLOTS_PER_BUCKET = 16;
	localparam int DEF_HEAP_DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int NODE_W = 24;
	localparam int BW_W = 16;
	localparam int HE_W = KEY_W + NODE_W;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} resp_t;

	typedef enum logic [4:0] {
		U_NOP, U_LOAD, U_CLEAR, U_DIV_PUSH, U_DIV_STEP, U_FILL_RD, U_PUT,
		U_HINS_INIT, U_HPAR_RD, U_HPAR_MOVE, U_HINS_FIN,
		U_SCAN_RD, U_SCAN_INC, U_POP_INIT, U_SLOT_RD, U_POP_FIN,
		U_RB_RD0, U_RB_INIT, U_RB_RD, U_RB_LATCH, U_RB_KEEP,
		U_HFY_INIT, U_SD_START, U_SD_CUR, U_SD_RDL, U_SD_LLATCH, U_SD_RLATCH,
		U_SD_MOVE, U_SD_FIN
	} uop_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_PUSH, S_DIV, S_FITS, S_FILLCHK, S_HINS, S_HUP, S_HCMP,
		S_SKIP, S_SKCHK, S_SLRD, S_SLEM, S_RB0, S_RBLOOP, S_RBLAT, S_RBKEEP,
		S_HFY, S_SDCUR, S_SDL, S_SDLL, S_SDRL, S_SDCMP, S_RESP
	} state_t;

	typedef struct packed {
		uop_t uop;
		logic src_rb;
		logic emit;
		resp_t emit_status;
		logic emit_node;
	} cmd_t;

	typedef struct packed {
		logic key_lt_base;
		logic div_last;
		logic fits;
		logic fill_ok;
		logic fill_zero;
		logic heap_full;
		logic hcnt_nz;
		logic i_zero;
		logic par_gt;
		logic scan_lt_biu;
		logic k_eq_n;
		logic out_idle;
		logic out_free;
		logic rb_more;
		logic hfy_more;
		logic has_left;
		logic child_lt;
	} sts_t;
endpackage
`default_nettype wire

// ----- hdl/bucketed_priority_frontier.sv -----
// Bucketed priority frontier: bucket queue with a min-heap overflow store.
// Input words (op, node_id, key) arrive on in_valid/in_ready; result words
// (status, out_node, last) leave on out_valid/out_ready; last marks the final word
// of each input word. bucket_width is written through cfg_we/cfg_data; the user
// must do so only while idle, as the block does not enforce it. One input word is
// worked on at a time; in_ready is high only between words. Push: the bucket index
// comes from a 32-step bit-serial divider; a node that goes to the heap then climbs
// it level by level. Pop: empty buckets are skipped, then each node is emitted in
// turn (output register drain, slot RAM read, output register load). An exhausted
// pop first rebuckets each heap entry through the divider, then sift-downs rebuild
// the heap. Clear and unused op codes answer with a single ST_OK word.
// Reset (arst_n low) empties the queue and sets bucket_width to 1; no clearing
// pass is needed. A stalled out_ready holds the output register and pauses the
// sequencer until the pending word is taken.
// Depends on bpf_pkg, bpf_ctrl, bpf_dp, bpf_ram.
`default_nettype none
module bucketed_priority_frontier #(
	parameter int NUM_BUCKETS = bpf_pkg::DEF_NUM_BUCKETS,
	parameter int SLOTS_PER_BUCKET = bpf_pkg::DEF_SLOTS_PER_BUCKET,
	parameter int HEAP_DEPTH = bpf_pkg::DEF_HEAP_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic [bpf_pkg::NODE_W-1:0] node_id,
	input wire logic [bpf_pkg::KEY_W-1:0] key,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic [bpf_pkg::NODE_W-1:0] out_node,
	output logic last,
	input wire logic cfg_we,
	input wire logic [bpf_pkg::BW_W-1:0] cfg_data
);
	import bpf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bpf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .sts(sts), .cmd(cmd)
	);

	bpf_dp #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
		.HEAP_DEPTH(HEAP_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .node_id(node_id), .key(key),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.out_node(out_node), .last(last)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a word while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("status word overwrites pending result");
	a_node_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_node |-> !out_valid)
		else $error("node word overwrites pending result");
	a_put_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == U_PUT |-> sts.fill_ok && sts.fits)
		else $error("bucket put without room");
`endif
endmodule
`default_nettype wire

// ----- hdl/bpf_ram.sv -----
// bpf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/bpf_ctrl.sv -----
// bpf_ctrl: sequencer of the bucketed priority frontier; issues micro-ops to bpf_dp.
// Depends on bpf_pkg.
`default_nettype none
module bpf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire bpf_pkg::sts_t sts,
	output bpf_pkg::cmd_t cmd
);
	import bpf_pkg::*;

	state_t state_q, state_d;
	resp_t resp_q, resp_d;
	logic rb_q, rb_d;
	logic rbd_q, rbd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resp_q <= ST_OK;
			rb_q <= 1'b0;
			rbd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			resp_q <= resp_d;
			rb_q <= rb_d;
			rbd_q <= rbd_d;
		end
	end

	always_comb begin
		state_d = state_q;
		resp_d = resp_q;
		rb_d = rb_q;
		rbd_d = rbd_q;
		in_ready = 1'b0;
		cmd = '{uop: U_NOP, src_rb: 1'b0, emit: 1'b0, emit_status: ST_OK, emit_node: 1'b0};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.uop = U_LOAD;
					rb_d = 1'b0;
					rbd_d = 1'b0;
					case (op_t'(op))
						OP_PUSH: state_d = S_PUSH;
						OP_POP: state_d = S_SKIP;
						OP_CLEAR: state_d = S_CLEAR;
						default: begin
							resp_d = ST_OK;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_CLEAR: begin
				cmd.uop = U_CLEAR;
				resp_d = ST_OK;
				state_d = S_RESP;
			end
			S_PUSH: begin
				if (sts.key_lt_base) begin
					state_d = S_HINS;
				end else begin
					cmd.uop = U_DIV_PUSH;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.uop = U_DIV_STEP;
				if (sts.div_last) begin
					state_d = S_FITS;
				end
			end
			S_FITS: begin
				if (sts.fits) begin
					cmd.uop = U_FILL_RD;
					state_d = S_FILLCHK;
				end else begin
					state_d = rb_q ? S_RBKEEP : S_HINS;
				end
			end
			S_FILLCHK: begin
				if (sts.fill_ok) begin
					cmd.uop = U_PUT;
					cmd.src_rb = rb_q;
					resp_d = ST_OK;
					state_d = rb_q ? S_RBLOOP : S_RESP;
				end else begin
					state_d = rb_q ? S_RBKEEP : S_HINS;
				end
			end
			S_HINS: begin
				if (sts.heap_full) begin
					resp_d = ST_FULL;
					state_d = S_RESP;
				end else begin
					cmd.uop = U_HINS_INIT;
					state_d = S_HUP;
				end
			end
			S_HUP: begin
				if (sts.i_zero) begin
					cmd.uop = U_HINS_FIN;
					resp_d = ST_OK;
					state_d = S_RESP;
				end else begin
					cmd.uop = U_HPAR_RD;
					state_d = S_HCMP;
				end
			end
			S_HCMP: begin
				if (sts.par_gt) begin
					cmd.uop = U_HPAR_MOVE;
					state_d = S_HUP;
				end else begin
					cmd.uop = U_HINS_FIN;
					resp_d = ST_OK;
					state_d = S_RESP;
				end
			end
			S_SKIP: begin
				if (sts.scan_lt_biu) begin
					cmd.uop = U_SCAN_RD;
					state_d = S_SKCHK;
				end else if (sts.hcnt_nz && !rbd_q) begin
					cmd.uop = U_RB_RD0;
					state_d = S_RB0;
				end else begin
					resp_d = ST_EMPTY;
					state_d = S_RESP;
				end
			end
			S_SKCHK: begin
				if (sts.fill_zero) begin
					cmd.uop = U_SCAN_INC;
					state_d = S_SKIP;
				end else begin
					cmd.uop = U_POP_INIT;
					state_d = S_SLRD;
				end
			end
			S_SLRD: begin
				if (sts.out_idle) begin
					cmd.uop = U_SLOT_RD;
					state_d = S_SLEM;
				end
			end
			S_SLEM: begin
				cmd.emit_node = 1'b1;
				if (sts.k_eq_n) begin
					cmd.uop = U_POP_FIN;
					state_d = S_IDLE;
				end else begin
					state_d = S_SLRD;
				end
			end
			S_RB0: begin
				cmd.uop = U_RB_INIT;
				rbd_d = 1'b1;
				rb_d = 1'b1;
				state_d = S_RBLOOP;
			end
			S_RBLOOP: begin
				if (sts.rb_more) begin
					cmd.uop = U_RB_RD;
					state_d = S_RBLAT;
				end else begin
					cmd.uop = U_HFY_INIT;
					state_d = S_HFY;
				end
			end
			S_RBLAT: begin
				cmd.uop = U_RB_LATCH;
				state_d = S_DIV;
			end
			S_RBKEEP: begin
				cmd.uop = U_RB_KEEP;
				state_d = S_RBLOOP;
			end
			S_HFY: begin
				if (sts.hfy_more) begin
					cmd.uop = U_SD_START;
					state_d = S_SDCUR;
				end else begin
					state_d = S_SKIP;
				end
			end
			S_SDCUR: begin
				cmd.uop = U_SD_CUR;
				state_d = S_SDL;
			end
			S_SDL: begin
				if (sts.has_left) begin
					cmd.uop = U_SD_RDL;
					state_d = S_SDLL;
				end else begin
					cmd.uop = U_SD_FIN;
					state_d = S_HFY;
				end
			end
			S_SDLL: begin
				cmd.uop = U_SD_LLATCH;
				state_d = S_SDRL;
			end
			S_SDRL: begin
				cmd.uop = U_SD_RLATCH;
				state_d = S_SDCMP;
			end
			S_SDCMP: begin
				if (sts.child_lt) begin
					cmd.uop = U_SD_MOVE;
					state_d = S_SDL;
				end else begin
					cmd.uop = U_SD_FIN;
					state_d = S_HFY;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_status = resp_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/bpf_dp.sv -----
// bpf_dp: datapath of the bucketed priority frontier: registers, divider, bucket and heap RAMs.
// Depends on bpf_pkg and bpf_ram; driven by micro-ops from bpf_ctrl.
`default_nettype none
module bpf_dp #(
	parameter int NUM_BUCKETS = bpf_pkg::DEF_NUM_BUCKETS,
	parameter int SLOTS_PER_BUCKET = bpf_pkg::DEF_SLOTS_PER_BUCKET,
	parameter int HEAP_DEPTH = bpf_pkg::DEF_HEAP_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [bpf_pkg::NODE_W-1:0] node_id,
	input wire logic [bpf_pkg::KEY_W-1:0] key,
	input wire logic cfg_we,
	input wire logic [bpf_pkg::BW_W-1:0] cfg_data,
	input wire bpf_pkg::cmd_t cmd,
	output bpf_pkg::sts_t sts,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic [bpf_pkg::NODE_W-1:0] out_node,
	output logic last
);
	import bpf_pkg::*;

	localparam int BIW = $clog2(NUM_BUCKETS);
	localparam int SW = $clog2(NUM_BUCKETS + 1);
	localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int SAW = $clog2(NUM_BUCKETS * SLOTS_PER_BUCKET);
	localparam int HIW = $clog2(HEAP_DEPTH);
	localparam int HCW = $clog2(HEAP_DEPTH + 1);

	logic [BW_W-1:0] width_q;
	logic [KEY_W-1:0] base_q, key_q, a_q;
	logic [NODE_W-1:0] node_q;
	logic [BW_W-1:0] r_q;
	logic [4:0] dcnt_q;
	logic [SW-1:0] scan_q, biu_q;
	logic [HCW-1:0] hcnt_q, i_q, j_q, m_q;
	logic [NUM_BUCKETS-1:0] vld_q;
	logic fvld_q;
	logic [FW-1:0] n_q, k_q;
	logic [HE_W-1:0] cur_q, l_q, rt_q;

	logic [BW_W-1:0] wdiv;
	logic [BW_W:0] rs, rsub;
	logic ge;
	logic [BIW-1:0] idx, scan_idx;
	logic [FW-1:0] fill_rd, fill_eff;
	logic [NODE_W-1:0] slot_rd;
	logic [HE_W-1:0] heap_rd, child;
	logic [HCW:0] li, ri, child_idx;
	logic has_right, c_is_r;
	logic [HCW-1:0] par;

	logic fill_we, fill_re, slot_we, slot_re, heap_we, heap_re;
	logic [BIW-1:0] fill_ra;
	logic [FW-1:0] fill_wd;
	logic [SAW-1:0] slot_wa, slot_ra;
	logic [NODE_W-1:0] slot_wd;
	logic [HIW-1:0] heap_wa, heap_ra;
	logic [HE_W-1:0] heap_wd;

	assign wdiv = (width_q == '0) ? BW_W'(1) : width_q;
	assign rs = {r_q, a_q[KEY_W-1]};
	assign ge = rs >= {1'b0, wdiv};
	assign rsub = rs - {1'b0, wdiv};
	assign idx = a_q[BIW-1:0];
	assign scan_idx = scan_q[BIW-1:0];
	assign fill_eff = fvld_q ? fill_rd : '0;
	assign par = (i_q - HCW'(1)) >> 1;
	assign li = {i_q, 1'b1};
	assign ri = li + (HCW+1)'(1);
	assign has_right = ri < (HCW+1)'(hcnt_q);
	assign c_is_r = has_right && (rt_q[HE_W-1 -: KEY_W] < l_q[HE_W-1 -: KEY_W]);
	assign child = c_is_r ? rt_q : l_q;
	assign child_idx = c_is_r ? ri : li;

	assign sts.key_lt_base = key_q < base_q;
	assign sts.div_last = dcnt_q == 5'd31;
	assign sts.fits = (a_q < KEY_W'(NUM_BUCKETS)) && (SW'(idx) >= scan_q);
	assign sts.fill_ok = fill_eff < FW'(SLOTS_PER_BUCKET);
	assign sts.fill_zero = fill_eff == '0;
	assign sts.heap_full = hcnt_q == HCW'(HEAP_DEPTH);
	assign sts.hcnt_nz = hcnt_q != '0;
	assign sts.i_zero = i_q == '0;
	assign sts.par_gt = heap_rd[HE_W-1 -: KEY_W] > key_q;
	assign sts.scan_lt_biu = scan_q < biu_q;
	assign sts.k_eq_n = k_q == n_q;
	assign sts.out_idle = !out_valid;
	assign sts.out_free = !out_valid || out_ready;
	assign sts.rb_more = i_q < hcnt_q;
	assign sts.hfy_more = j_q != '0;
	assign sts.has_left = li < (HCW+1)'(hcnt_q);
	assign sts.child_lt = child[HE_W-1 -: KEY_W] < cur_q[HE_W-1 -: KEY_W];

	always_comb begin
		fill_re = (cmd.uop == U_SCAN_RD) || (cmd.uop == U_FILL_RD);
		fill_ra = (cmd.uop == U_SCAN_RD) ? scan_idx : idx;
		fill_we = cmd.uop == U_PUT;
		fill_wd = fill_eff + FW'(1);
		slot_we = cmd.uop == U_PUT;
		slot_wa = SAW'(SAW'(idx) * SAW'(SLOTS_PER_BUCKET) + SAW'(fill_eff));
		slot_wd = cmd.src_rb ? cur_q[NODE_W-1:0] : node_q;
		slot_re = cmd.uop == U_SLOT_RD;
		slot_ra = SAW'(SAW'(scan_idx) * SAW'(SLOTS_PER_BUCKET) + SAW'(k_q));
		heap_re = 1'b1;
		heap_ra = '0;
		case (cmd.uop)
			U_HPAR_RD: heap_ra = par[HIW-1:0];
			U_RB_RD: heap_ra = i_q[HIW-1:0];
			U_SD_START: heap_ra = HIW'(j_q - HCW'(1));
			U_SD_RDL: heap_ra = li[HIW-1:0];
			U_SD_LLATCH: heap_ra = ri[HIW-1:0];
			default: heap_re = cmd.uop == U_RB_RD0;
		endcase
		heap_we = 1'b1;
		heap_wa = i_q[HIW-1:0];
		heap_wd = cur_q;
		case (cmd.uop)
			U_HPAR_MOVE: heap_wd = heap_rd;
			U_HINS_FIN: heap_wd = {key_q, node_q};
			U_RB_KEEP: heap_wa = m_q[HIW-1:0];
			U_SD_MOVE: heap_wd = child;
			U_SD_FIN: heap_wd = cur_q;
			default: heap_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= BW_W'(1);
			base_q <= '0;
			scan_q <= '0;
			biu_q <= '0;
			hcnt_q <= '0;
			vld_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_data;
			end
			if (cmd.emit || cmd.emit_node) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (cmd.uop)
				U_CLEAR: begin
					base_q <= '0;
					scan_q <= '0;
					biu_q <= '0;
					hcnt_q <= '0;
					vld_q <= '0;
				end
				U_PUT: begin
					vld_q[idx] <= 1'b1;
					if (SW'(idx) + SW'(1) > biu_q) begin
						biu_q <= SW'(idx) + SW'(1);
					end
				end
				U_HINS_FIN: hcnt_q <= hcnt_q + HCW'(1);
				U_SCAN_INC: scan_q <= scan_q + SW'(1);
				U_POP_FIN: begin
					vld_q[scan_idx] <= 1'b0;
					scan_q <= scan_q + SW'(1);
				end
				U_RB_INIT: begin
					base_q <= heap_rd[HE_W-1 -: KEY_W];
					scan_q <= '0;
					biu_q <= '0;
					vld_q <= '0;
				end
				U_HFY_INIT: hcnt_q <= m_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fill_re) begin
			fvld_q <= vld_q[fill_ra];
		end
		if (cmd.emit) begin
			status <= cmd.emit_status;
			out_node <= '0;
			last <= 1'b1;
		end else if (cmd.emit_node) begin
			status <= ST_OK;
			out_node <= slot_rd;
			last <= k_q == n_q;
		end
		case (cmd.uop)
			U_LOAD: begin
				key_q <= key;
				node_q <= node_id;
			end
			U_DIV_PUSH: begin
				a_q <= key_q - base_q;
				r_q <= '0;
				dcnt_q <= '0;
			end
			U_RB_LATCH: begin
				cur_q <= heap_rd;
				a_q <= heap_rd[HE_W-1 -: KEY_W] - base_q;
				r_q <= '0;
				dcnt_q <= '0;
			end
			U_DIV_STEP: begin
				a_q <= {a_q[KEY_W-2:0], ge};
				r_q <= ge ? rsub[BW_W-1:0] : rs[BW_W-1:0];
				dcnt_q <= dcnt_q + 5'd1;
			end
			U_PUT: begin
				if (cmd.src_rb) begin
					i_q <= i_q + HCW'(1);
				end
			end
			U_HINS_INIT: i_q <= hcnt_q;
			U_HPAR_MOVE: i_q <= par;
			U_POP_INIT: begin
				n_q <= fill_eff;
				k_q <= '0;
			end
			U_SLOT_RD: k_q <= k_q + FW'(1);
			U_RB_INIT: begin
				i_q <= '0;
				m_q <= '0;
			end
			U_RB_KEEP: begin
				m_q <= m_q + HCW'(1);
				i_q <= i_q + HCW'(1);
			end
			U_HFY_INIT: j_q <= m_q >> 1;
			U_SD_START: begin
				j_q <= j_q - HCW'(1);
				i_q <= j_q - HCW'(1);
			end
			U_SD_CUR: cur_q <= heap_rd;
			U_SD_LLATCH: l_q <= heap_rd;
			U_SD_RLATCH: rt_q <= heap_rd;
			U_SD_MOVE: i_q <= child_idx[HCW-1:0];
			default: ;
		endcase
	end

	bpf_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill (
		.clk(clk), .we(fill_we), .waddr(idx), .wdata(fill_wd),
		.re(fill_re), .raddr(fill_ra), .rdata(fill_rd)
	);

	bpf_ram #(.WIDTH(NODE_W), .DEPTH(NUM_BUCKETS * SLOTS_PER_BUCKET)) u_slots (
		.clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
		.re(slot_re), .raddr(slot_ra), .rdata(slot_rd)
	);

	bpf_ram #(.WIDTH(HE_W), .DEPTH(HEAP_DEPTH)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
		.re(heap_re), .raddr(heap_ra), .rdata(heap_rd)
	);
endmodule
`default_nettype wire

// ----- test/bucketed_priority_frontier_tb.sv -----
// Self-checking testbench for bucketed_priority_frontier: random and directed push/pop/clear
// words checked against an in-bench bucket queue and overflow heap predictor.
// Depends on bpf_pkg and the bucketed_priority_frontier RTL.
`default_nettype none
module bucketed_priority_frontier_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bpf_pkg::*;

	localparam int NB = DEF_NUM_BUCKETS;
	localparam int SPB = DEF_SLOTS_PER_BUCKET;
	localparam int HD = DEF_HEAP_DEPTH;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 10000000;

	typedef struct {
		logic [1:0] op;
		logic [NODE_W-1:0] node;
		logic [KEY_W-1:0] key;
	} word_t;

	typedef struct {
		logic [1:0] status;
		logic [NODE_W-1:0] node;
		logic last;
	} result_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0, cfg_we = 0;
	logic in_ready, out_valid, last;
	logic [1:0] op = '0, status;
	logic [NODE_W-1:0] node_id = '0, out_node;
	logic [KEY_W-1:0] key = '0;
	logic [BW_W-1:0] cfg_data = '0;

	bucketed_priority_frontier u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .node_id(node_id), .key(key),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_node(out_node), .last(last),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	word_t pending_words[$];
	result_t expected_results[$];
	int errors = 0, words_taken = 0, nodes_popped = 0, drops_seen = 0;
	bit quiet = 0, held = 0;
	int in_gap = 0, out_gap = 0, hold_cnt = 0;
	longint cycles = 0;

	// predictor state
	logic [BW_W-1:0] pw_width = 1;
	logic [KEY_W-1:0] pq_base = 0;
	int pq_scan = 0, pq_biu = 0, pq_total = 0, pq_hcnt = 0;
	int pq_fill[NB];
	logic [NODE_W-1:0] pq_slot[NB][SPB];
	logic [KEY_W-1:0] pq_hkey[HD];
	logic [NODE_W-1:0] pq_hnode[HD];

	initial forever #5 clk = ~clk;

	task automatic report(string msg);
		errors++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	function automatic logic [31:0] width_eff();
		return (pw_width == 0) ? 32'd1 : {16'd0, pw_width};
	endfunction

	task automatic heap_swap(int a, int b);
		logic [KEY_W-1:0] tk;
		logic [NODE_W-1:0] tn;
		tk = pq_hkey[a]; pq_hkey[a] = pq_hkey[b]; pq_hkey[b] = tk;
		tn = pq_hnode[a]; pq_hnode[a] = pq_hnode[b]; pq_hnode[b] = tn;
	endtask

	task automatic sift_down(int i, int n);
		int l, c;
		forever begin
			l = 2 * i + 1;
			if (l >= n) return;
			c = l;
			if (l + 1 < n && pq_hkey[l + 1] < pq_hkey[l]) c = l + 1;
			if (!(pq_hkey[c] < pq_hkey[i])) return;
			heap_swap(c, i);
			i = c;
		end
	endtask

	task automatic bucket_put(int idx, logic [NODE_W-1:0] n);
		pq_slot[idx][pq_fill[idx]] = n;
		pq_fill[idx]++;
		if (idx + 1 > pq_biu) pq_biu = idx + 1;
	endtask

	task automatic rebucket();
		int m;
		logic [31:0] idx;
		m = 0;
		pq_base = pq_hkey[0];
		pq_scan = 0;
		pq_biu = 0;
		foreach (pq_fill[b]) pq_fill[b] = 0;
		for (int i = 0; i < pq_hcnt; i++) begin
			idx = (pq_hkey[i] - pq_base) / width_eff();
			if (idx < NB && pq_fill[idx] < SPB) begin
				bucket_put(idx, pq_hnode[i]);
			end else begin
				pq_hkey[m] = pq_hkey[i];
				pq_hnode[m] = pq_hnode[i];
				m++;
			end
		end
		pq_hcnt = m;
		for (int i = m / 2 - 1; i >= 0; i--) sift_down(i, m);
	endtask

	task automatic skip_empty();
		while (pq_scan < pq_biu && pq_fill[pq_scan] == 0) pq_scan++;
	endtask

	task automatic expect_word(result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic predict_word(word_t w);
		result_t r;
		logic [31:0] idx;
		int i, p, n;
		r = '{status: ST_OK, node: '0, last: 1'b1};
		case (w.op)
			OP_PUSH: begin
				idx = 0;
				if (w.key >= pq_base) idx = (w.key - pq_base) / width_eff();
				if (w.key >= pq_base && idx < NB && idx >= pq_scan && pq_fill[idx] < SPB) begin
					bucket_put(idx, w.node);
					pq_total++;
				end else if (pq_hcnt < HD) begin
					i = pq_hcnt;
					while (i > 0) begin
						p = (i - 1) / 2;
						if (!(pq_hkey[p] > w.key)) break;
						pq_hkey[i] = pq_hkey[p];
						pq_hnode[i] = pq_hnode[p];
						i = p;
					end
					pq_hkey[i] = w.key;
					pq_hnode[i] = w.node;
					pq_hcnt++;
					pq_total++;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_POP: begin
				skip_empty();
				if (pq_scan >= pq_biu && pq_hcnt > 0) begin
					rebucket();
					skip_empty();
				end
				if (pq_scan < pq_biu) begin
					n = pq_fill[pq_scan];
					for (int k = 0; k < n; k++)
						expect_word('{ST_OK, pq_slot[pq_scan][k], k + 1 == n});
					pq_total -= n;
					pq_fill[pq_scan] = 0;
					pq_scan++;
					return;
				end
				r.status = ST_EMPTY;
			end
			OP_CLEAR: begin
				pq_base = 0; pq_scan = 0; pq_biu = 0; pq_total = 0; pq_hcnt = 0;
				foreach (pq_fill[b]) pq_fill[b] = 0;
			end
			default: ;
		endcase
		expect_word(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		logic nv;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				predict_word('{op, node_id, key});
				words_taken++;
				nv = 0;
				if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 7);
			end
			if (!nv) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					op <= w.op;
					node_id <= w.node;
					key <= w.key;
					nv = 1;
				end
			end
			in_valid <= nv;
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held <= 0;
			hold_cnt <= 0;
		end else if (!held && words_taken >= 120) begin
			held <= 1;
			hold_cnt <= 400;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected word st=%0d node=%0h", status, out_node));
				end else begin
					e = expected_results.pop_front();
					if (status !== e.status)
						report($sformatf("status %0d, want %0d", status, e.status));
					if (out_node !== e.node)
						report($sformatf("out_node %0h, want %0h", out_node, e.node));
					if (last !== e.last)
						report($sformatf("last %0b, want %0b", last, e.last));
					if (e.status == ST_OK && e.node != 0) nodes_popped++;
					if (e.status == ST_FULL) drops_seen++;
				end
			end
			if (hold_cnt > 0) begin
				out_ready <= 0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 6);
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic add(logic [1:0] o, logic [NODE_W-1:0] n, logic [KEY_W-1:0] k);
		pending_words.insert(pending_words.size(), '{o, n, k});
	endtask

	// mode 0: mixed near keys, 1: heap flood with far keys
	task automatic add_random(int count, int mode);
		int r;
		logic [31:0] k;
		logic [31:0] w;
		w = width_eff();
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: k = $urandom;
				1: k = 32'hFFFF_FFFF - $urandom_range(0, 3);
				2, 3: k = $urandom_range(0, 3) * w;
				default: k = $urandom_range(0, 90) * w + $urandom_range(0, w - 1);
			endcase
			if (mode == 1) k = $urandom;
			if (mode == 1 ? r < 90 : r < 58) add(OP_PUSH, $urandom, k);
			else if (r < 95) add(OP_POP, $urandom, $urandom);
			else if (r < 98) add(OP_CLEAR, $urandom, $urandom);
			else add(OP_UNUSED, $urandom, $urandom);
		end
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_width(logic [BW_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		pw_width = v;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		set_width(1);
		// directed: extremes, empty pop, below-scan push, clear, unused op
		add(OP_POP, 0, 0);
		add(OP_PUSH, 24'h000000, 32'h0000_0000);
		add(OP_PUSH, 24'hFFFFFF, 32'hFFFF_FFFF);
		add(OP_PUSH, 24'h123456, 32'd63);
		add(OP_PUSH, 24'hABCDEF, 32'd64);
		add(OP_PUSH, 24'h555555, 32'd1);
		add(OP_PUSH, 24'hAAAAAA, 32'd1);
		add(OP_POP, 0, 0);
		add(OP_POP, 0, 0);
		add(OP_PUSH, 24'h0F0F0F, 32'd0);
		add(OP_POP, 24'hFFFFFF, 32'hFFFF_FFFF);
		add(OP_POP, 0, 0);
		add(OP_POP, 0, 0);
		add(OP_POP, 0, 0);
		add(OP_UNUSED, 24'hFFFFFF, 32'hFFFF_FFFF);
		add(OP_PUSH, 24'h000001, 32'd5);
		add(OP_CLEAR, 24'hFFFFFF, 32'hFFFF_FFFF);
		add(OP_POP, 0, 0);
		add(OP_POP, 0, 0);
		drain();
		set_width(0);
		add_random(60, 0);
		drain();
		set_width(16'hFFFF);
		add_random(80, 1);
		add_random(20, 0);
		drain();
		set_width(BW_W'($urandom_range(2, 300)));
		add_random(50, 0);
		drain();
		set_width(3);
		quiet = 1;
		add_random(40, 0);
		for (int i = 0; i < 6; i++) add(OP_POP, 0, 0);
		drain();
		$display("covered %0d words over five bucket widths: %0d nodes popped, %0d drops",
			words_taken, nodes_popped, drops_seen);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
